// ===== rtl/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants for the indexed list engine
// Field widths, operation and status codes, and the command word that is
// broadcast along the chain of list cells.
// ----------------------------------------------------------------------------
package ile_pkg;

	// default sizing
	localparam int ILE_CAPACITY  = 16;
	localparam int ILE_MAX_WORDS = 4;

	// fixed field widths
	localparam int OPC_W    = 4;
	localparam int POS_W    = 5;
	localparam int WCNT_W   = 3;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 5;
	localparam int IN_WORDS = 4;

	// slot index width, covers the largest supported capacity
	localparam int SLOT_W = 8;

	typedef logic [OPC_W-1:0] opcode_t;
	localparam opcode_t OP_PUSH_BACK  = 4'd0;
	localparam opcode_t OP_PUSH_FRONT = 4'd1;
	localparam opcode_t OP_POP_BACK   = 4'd2;
	localparam opcode_t OP_POP_FRONT  = 4'd3;
	localparam opcode_t OP_INSERT     = 4'd4;
	localparam opcode_t OP_REMOVE     = 4'd5;
	localparam opcode_t OP_GET        = 4'd6;
	localparam opcode_t OP_FRONT      = 4'd7;
	localparam opcode_t OP_BACK       = 4'd8;
	localparam opcode_t OP_CLEAR      = 4'd9;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// shift command seen by every cell
	typedef struct packed {
		logic              ins;   // open a gap at slot, load new entry there
		logic              rem;   // close the gap at slot
		logic [SLOT_W-1:0] slot;
	} ile_cmd_t;

endpackage

// ===== rtl/ile_cell.sv =====
// ----------------------------------------------------------------------------
// ile_cell: one list slot
// Holds one entry (payload words and word count). On an insert it loads the
// new entry or its left neighbour; on a removal it loads its right neighbour.
// ----------------------------------------------------------------------------
module ile_cell
	import ile_pkg::*;
#(
	parameter int IDX       = 0,
	parameter int MAX_WORDS = ILE_MAX_WORDS
) (
	input  logic                              clk,
	input  ile_cmd_t                          cmd,
	input  logic [MAX_WORDS-1:0][WORD_W-1:0] new_words,
	input  logic [WCNT_W-1:0]                 new_count,
	input  logic [MAX_WORDS-1:0][WORD_W-1:0] left_words,
	input  logic [WCNT_W-1:0]                 left_count,
	input  logic [MAX_WORDS-1:0][WORD_W-1:0] right_words,
	input  logic [WCNT_W-1:0]                 right_count,
	output logic [MAX_WORDS-1:0][WORD_W-1:0] words,
	output logic [WCNT_W-1:0]                 count
);

	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

	logic [MAX_WORDS-1:0][WORD_W-1:0] words_q;
	logic [WCNT_W-1:0]                 count_q;
	logic                              at_slot;
	logic                              above_slot;

	assign at_slot    = (cmd.slot == MY_SLOT);
	assign above_slot = (cmd.slot < MY_SLOT);

	// entry register, no reset: contents are meaningless until written
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at_slot) begin
				words_q <= new_words;
				count_q <= new_count;
			end else if (above_slot) begin
				words_q <= left_words;
				count_q <= left_count;
			end
		end else if (cmd.rem && (at_slot || above_slot)) begin
			words_q <= right_words;
			count_q <= right_count;
		end
	end

	assign words = words_q;
	assign count = count_q;

endmodule

// ===== rtl/ile_chain.sv =====
// ----------------------------------------------------------------------------
// ile_chain: row of list cells
// Links the cells to their neighbours and selects one entry for reading.
// ----------------------------------------------------------------------------
module ile_chain
	import ile_pkg::*;
#(
	parameter int CAPACITY  = ILE_CAPACITY,
	parameter int MAX_WORDS = ILE_MAX_WORDS,
	localparam int IW       = $clog2(CAPACITY)
) (
	input  logic                              clk,
	input  ile_cmd_t                          cmd,
	input  logic [MAX_WORDS-1:0][WORD_W-1:0] new_words,
	input  logic [WCNT_W-1:0]                 new_count,
	input  logic [IW-1:0]                     rd_idx,
	output logic [MAX_WORDS-1:0][WORD_W-1:0] rd_words,
	output logic [WCNT_W-1:0]                 rd_count
);

	logic [CAPACITY-1:0][MAX_WORDS-1:0][WORD_W-1:0] cell_words;
	logic [CAPACITY-1:0][WCNT_W-1:0]                 cell_count;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [MAX_WORDS-1:0][WORD_W-1:0] l_words;
		logic [WCNT_W-1:0]                 l_count;
		logic [MAX_WORDS-1:0][WORD_W-1:0] r_words;
		logic [WCNT_W-1:0]                 r_count;

		// first cell never takes from the left
		if (i == 0) begin : g_first
			assign l_words = '0;
			assign l_count = '0;
		end else begin : g_mid_l
			assign l_words = cell_words[i-1];
			assign l_count = cell_count[i-1];
		end

		// last cell keeps its own entry on a removal
		if (i == CAPACITY - 1) begin : g_last
			assign r_words = cell_words[i];
			assign r_count = cell_count[i];
		end else begin : g_mid_r
			assign r_words = cell_words[i+1];
			assign r_count = cell_count[i+1];
		end

		ile_cell #(
			.IDX       (i),
			.MAX_WORDS (MAX_WORDS)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.new_words   (new_words),
			.new_count   (new_count),
			.left_words  (l_words),
			.left_count  (l_count),
			.right_words (r_words),
			.right_count (r_count),
			.words       (cell_words[i]),
			.count       (cell_count[i])
		);
	end

	// read select
	assign rd_words = cell_words[rd_idx];
	assign rd_count = cell_count[rd_idx];

endmodule

// ===== rtl/indexed_list_engine_top.sv =====
// Indexed list engine.
// A taken start sets the execute register (busy), which in turn sets the done
// register; busy is high for the cycle in between, and no start is taken then.
// The cell chain shifts all entries in the same cycle, and the result register
// follows it. Results cannot be stalled.
// Reset clears the length and control flags; entry contents are not cleared.
// ----------------------------------------------------------------------------
// indexed_list_engine_top: positional list with insert and remove
// Decodes one operation, drives the cell chain shift command and registers
// the status, the entry read and the new length.
// ----------------------------------------------------------------------------
module indexed_list_engine_top
	import ile_pkg::*;
#(
	parameter int CAPACITY  = ILE_CAPACITY,
	parameter int MAX_WORDS = ILE_MAX_WORDS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [OPC_W-1:0]           opcode,
	input  logic [POS_W-1:0]           position,
	input  logic [WCNT_W-1:0]          word_count,
	input  logic signed [WORD_W-1:0]   in_word0,
	input  logic signed [WORD_W-1:0]   in_word1,
	input  logic signed [WORD_W-1:0]   in_word2,
	input  logic signed [WORD_W-1:0]   in_word3,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic [WCNT_W-1:0]          out_count,
	output logic signed [WORD_W-1:0]   out_word0,
	output logic signed [WORD_W-1:0]   out_word1,
	output logic signed [WORD_W-1:0]   out_word2,
	output logic signed [WORD_W-1:0]   out_word3,
	output logic [LEN_W-1:0]           list_length
);

	localparam int IW  = $clog2(CAPACITY);
	localparam int LW  = $clog2(CAPACITY + 1);
	localparam int CW  = ((LW > POS_W) ? LW : POS_W) + 1;
	localparam int PW  = (MAX_WORDS > IN_WORDS) ? MAX_WORDS : IN_WORDS;
	localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

	// control and operation registers
	logic                              exec_q;
	logic                              done_q;
	logic [LW-1:0]                     len_q;
	opcode_t                           op_q;
	logic [POS_W-1:0]                  pos_q;
	logic [WCNT_W-1:0]                 wc_q;
	logic [IN_WORDS-1:0][WORD_W-1:0]   in_words_q;

	// result registers
	status_t                           res_status_q;
	logic [WCNT_W-1:0]                 res_count_q;
	logic [IN_WORDS-1:0][WORD_W-1:0]   res_words_q;

	// decode
	ile_cmd_t                          cmd;
	status_t                           status_d;
	logic [LW-1:0]                     len_d;
	logic                              rd_en;
	logic [SLOT_W-1:0]                 rd_slot;
	logic [CW-1:0]                     pos_x;
	logic [CW-1:0]                     len_x;
	logic                              empty;
	logic                              full;

	// chain side
	logic [MAX_WORDS-1:0][WORD_W-1:0]  new_words;
	logic [WCNT_W-1:0]                 new_count;
	logic [MAX_WORDS-1:0][WORD_W-1:0]  rd_words;
	logic [WCNT_W-1:0]                 rd_count;
	logic [PW-1:0][WORD_W-1:0]         in_pad;
	logic [PW-1:0][WORD_W-1:0]         rd_pad;
	logic [IN_WORDS-1:0][WORD_W-1:0]   out_d;
	logic [WCNT_W-1:0]                 count_d;

	// operation decode, active in the execute cycle only
	always_comb begin
		pos_x    = CW'(pos_q);
		len_x    = CW'(len_q);
		empty    = (len_q == '0);
		full     = (len_q == CAP_L);
		cmd      = '0;
		status_d = ST_DONE;
		len_d    = len_q;
		rd_en    = 1'b0;
		rd_slot  = '0;
		case (op_q)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.ins  = exec_q;
					cmd.slot = (op_q == OP_PUSH_BACK) ? SLOT_W'(len_q) : '0;
					len_d    = len_q + 1'b1;
				end
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_IGNORED;
				end else begin
					cmd.rem  = exec_q;
					cmd.slot = (op_q == OP_POP_BACK) ? SLOT_W'(len_q - 1'b1) : '0;
					len_d    = len_q - 1'b1;
				end
			end
			OP_INSERT: begin
				if (pos_x == '0 || pos_x > len_x + 1'b1) begin
					status_d = ST_IGNORED;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.ins  = exec_q;
					cmd.slot = SLOT_W'(pos_x - 1'b1);
					len_d    = len_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (pos_x == '0 || pos_x > len_x) begin
					status_d = ST_IGNORED;
				end else begin
					cmd.rem  = exec_q;
					cmd.slot = SLOT_W'(pos_x - 1'b1);
					len_d    = len_q - 1'b1;
				end
			end
			OP_GET: begin
				if (pos_x == '0 || pos_x > len_x) begin
					status_d = ST_IGNORED;
				end else begin
					rd_en   = 1'b1;
					rd_slot = SLOT_W'(pos_x - 1'b1);
				end
			end
			OP_FRONT, OP_BACK: begin
				if (empty) begin
					status_d = ST_IGNORED;
				end else begin
					rd_en   = 1'b1;
					rd_slot = (op_q == OP_BACK) ? SLOT_W'(len_q - 1'b1) : '0;
				end
			end
			OP_CLEAR: begin
				len_d = '0;
			end
			default: begin
				status_d = ST_IGNORED;
			end
		endcase
	end

	// new entry: saturate the count, zero words beyond it
	always_comb begin
		in_pad = (PW*WORD_W)'(in_words_q);
		if ({1'b0, wc_q} > (WCNT_W+1)'(MAX_WORDS)) begin
			new_count = WCNT_W'(MAX_WORDS);
		end else begin
			new_count = wc_q;
		end
		for (int j = 0; j < MAX_WORDS; j++) begin
			new_words[j] = (j < int'(new_count)) ? in_pad[j] : '0;
		end
	end

	ile_chain #(
		.CAPACITY  (CAPACITY),
		.MAX_WORDS (MAX_WORDS)
	) u_chain (
		.clk       (clk),
		.cmd       (cmd),
		.new_words (new_words),
		.new_count (new_count),
		.rd_idx    (rd_slot[IW-1:0]),
		.rd_words  (rd_words),
		.rd_count  (rd_count)
	);

	// read data, masked by the stored count
	always_comb begin
		rd_pad  = (PW*WORD_W)'(rd_words);
		count_d = rd_en ? rd_count : '0;
		for (int j = 0; j < IN_WORDS; j++) begin
			out_d[j] = (j < int'(count_d)) ? rd_pad[j] : '0;
		end
	end

	// control flags and length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_q <= 1'b0;
			done_q <= 1'b0;
			len_q  <= '0;
		end else begin
			exec_q <= start && !exec_q;
			done_q <= exec_q;
			if (exec_q) begin
				len_q <= len_d;
			end
		end
	end

	// operation and result payload
	always_ff @(posedge clk) begin
		if (start && !exec_q) begin
			op_q       <= opcode_t'(opcode);
			pos_q      <= position;
			wc_q       <= word_count;
			in_words_q <= {in_word3, in_word2, in_word1, in_word0};
		end
		if (exec_q) begin
			res_status_q <= status_d;
			res_count_q  <= count_d;
			res_words_q  <= out_d;
		end
	end

	assign busy        = exec_q;
	assign done        = done_q;
	assign status      = res_status_q;
	assign out_count   = res_count_q;
	assign out_word0   = res_words_q[0];
	assign out_word1   = res_words_q[1];
	assign out_word2   = res_words_q[2];
	assign out_word3   = res_words_q[3];
	assign list_length = LEN_W'(len_q);

`ifndef NO_ASSERTIONS
	// an operation never overlaps the delivery of the previous result
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(exec_q && done_q))
		else $error("execute and result cycles overlap");

	// a taken operation always executes next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !exec_q) |=> exec_q)
		else $error("accepted operation did not execute");

	// every execute cycle yields exactly one result
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		exec_q |=> done_q)
		else $error("execute cycle without result");

	// length stays within capacity
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CAP_L)
		else $error("list length beyond capacity");

	// a shift command is only issued while executing, never both kinds
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && cmd.rem) && (!(cmd.ins || cmd.rem) || exec_q))
		else $error("bad shift command");
`endif

endmodule
